// File: design/read_pair_link_accumulator_top_macros.svh
// Assertion macros shared by the checker of the link accumulator.
`ifndef READ_PAIR_LINK_ACCUMULATOR_TOP_MACROS_SVH
`define READ_PAIR_LINK_ACCUMULATOR_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RPLA_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("rpla check failed");
// Next-cycle implication checked outside reset.
`define RPLA_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("rpla check failed");
`endif

// File: design/rpla_pkg.sv
// Package with types and constants of the read pair link accumulator.
package rpla_pkg;
    localparam int MAX_CONTIGS = 1024;
    localparam int MAX_EDGES   = 4096;
    localparam int COORD_BITS  = 30;
    localparam logic [15:0] SLACK_RESET = 16'd200;

    localparam logic [2:0] ST_LOADED  = 3'd0;
    localparam logic [2:0] ST_BAD_A   = 3'd1;
    localparam logic [2:0] ST_BAD_B   = 3'd2;
    localparam logic [2:0] ST_SAME    = 3'd3;
    localparam logic [2:0] ST_UPDATED = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    localparam logic [0:0] REG_MATCH_SLACK = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [10:0] contig_a;
        logic [1:0]  flags_a;
        logic [7:0]  hits_a;
        logic [27:0] start_a;
        logic [15:0] span_a;
        logic [10:0] contig_b;
        logic [1:0]  flags_b;
        logic [7:0]  hits_b;
        logic [27:0] start_b;
        logic [15:0] span_b;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] forward_edge;
        logic        forward_created;
        logic [11:0] mirror_edge;
        logic        mirror_created;
    } t_out;

    // Result of one link search handed from the edge engine to the control.
    typedef struct packed {
        logic        done;
        logic        ok;
        logic [11:0] edge_idx;
        logic        created;
    } t_link_res;
endpackage

// File: design/rpla_if.sv
// Valid/ready channel interface carrying one payload per beat.
interface rpla_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/rpla_edge_engine.sv
// Edge table memory and the sequential scan, update and append engine.
module rpla_edge_engine #(
    parameter int MAX_EDGES  = rpla_pkg::MAX_EDGES,
    parameter int COORD_BITS = rpla_pkg::COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [10:0]                   i_v1,
    input  logic [10:0]                   i_v2,
    input  logic signed [COORD_BITS-1:0]  i_f1,
    input  logic signed [COORD_BITS-1:0]  i_g1,
    input  logic signed [COORD_BITS-1:0]  i_f2,
    input  logic signed [COORD_BITS-1:0]  i_g2,
    input  logic [15:0]                   i_slack,
    output rpla_pkg::t_link_res           o_res
);
    import rpla_pkg::*;

    localparam int AW = $clog2(MAX_EDGES);
    localparam int UW = $clog2(MAX_EDGES + 1);
    localparam int CW = COORD_BITS + 2;
    localparam int RW = 22 + 4 * COORD_BITS + 32;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CHECK = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    logic [RW-1:0] mem [MAX_EDGES];
    logic [RW-1:0] r_rd;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [RW-1:0] mem_wdata;

    t_state r_state, n_state;
    logic [UW-1:0] r_used, n_used;
    logic [UW-1:0] r_idx, n_idx;
    t_link_res     r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[rd_addr];
    end

    logic [10:0] e_src, e_dst;
    logic signed [COORD_BITS-1:0] e_sb, e_se, e_db, e_de;
    logic [31:0] e_w;
    assign {e_src, e_dst, e_sb, e_se, e_db, e_de, e_w} = r_rd;

    function automatic logic win(input logic signed [CW-1:0] x,
                                 input logic signed [CW-1:0] lo,
                                 input logic signed [CW-1:0] hi,
                                 input logic signed [CW-1:0] s);
        return (lo - s <= x) && (x <= hi + s);
    endfunction

    function automatic logic iv_match(input logic signed [COORD_BITS-1:0] b,
                                      input logic signed [COORD_BITS-1:0] e,
                                      input logic signed [COORD_BITS-1:0] f,
                                      input logic signed [COORD_BITS-1:0] g,
                                      input logic [15:0] sl);
        logic signed [CW-1:0] bb, ee, ff, gg, ss;
        bb = CW'(b); ee = CW'(e); ff = CW'(f); gg = CW'(g);
        ss = CW'($signed({1'b0, sl}));
        if (f < g) begin
            if (b >= e) return 1'b0;
            return win(ff, bb, ee, ss) || win(gg, bb, ee, ss) ||
                   win(bb, ff, gg, ss) || win(ee, ff, gg, ss);
        end
        if (b <= e) return 1'b0;
        return win(ff, ee, bb, ss) || win(gg, ee, bb, ss) ||
               win(bb, gg, ff, ss) || win(ee, gg, ff, ss);
    endfunction

    logic hit;
    assign hit = (e_src == i_v1) && (e_dst == i_v2) &&
                 iv_match(e_sb, e_se, i_f1, i_g1, i_slack) &&
                 iv_match(e_db, e_de, i_f2, i_g2, i_slack);

    logic signed [COORD_BITS-1:0] w_sb, w_se, w_db, w_de;
    always_comb begin
        if (i_f1 < i_g1) begin
            w_sb = (i_f1 < e_sb) ? i_f1 : e_sb;
            w_se = (i_g1 > e_se) ? i_g1 : e_se;
        end else begin
            w_sb = (i_f1 > e_sb) ? i_f1 : e_sb;
            w_se = (i_g1 < e_se) ? i_g1 : e_se;
        end
        if (i_f2 < i_g2) begin
            w_db = (i_f2 < e_db) ? i_f2 : e_db;
            w_de = (i_g2 > e_de) ? i_g2 : e_de;
        end else begin
            w_db = (i_f2 > e_db) ? i_f2 : e_db;
            w_de = (i_g2 < e_de) ? i_g2 : e_de;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_idx     = r_idx;
        n_res     = r_res;
        n_res.done = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = r_rd;
        rd_addr   = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_idx   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_idx >= r_used) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (hit) begin
                    mem_we    = 1'b1;
                    mem_wdata = {e_src, e_dst, w_sb, w_se, w_db, w_de,
                                 (e_w == 32'hFFFF_FFFF) ? e_w : e_w + 32'd1};
                    n_res     = '{done: 1'b1, ok: 1'b1,
                                  edge_idx: 12'(r_idx), created: 1'b0};
                    n_state   = S_IDLE;
                end else begin
                    n_idx   = r_idx + UW'(1);
                    n_state = S_READ;
                end
            end
            S_WRITE: begin
                if (r_used >= UW'(MAX_EDGES)) begin
                    n_res = '{done: 1'b1, ok: 1'b0, edge_idx: 12'd0, created: 1'b0};
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_used[AW-1:0];
                    mem_wdata = {i_v1, i_v2, i_f1, i_g1, i_f2, i_g2, 32'd1};
                    n_res     = '{done: 1'b1, ok: 1'b1,
                                  edge_idx: 12'(r_used), created: 1'b1};
                    n_used    = r_used + UW'(1);
                end
                n_state = S_IDLE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_idx   <= '0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_idx   <= n_idx;
            r_res   <= n_res;
        end
    end

    assign o_res = r_res;
endmodule

// File: design/read_pair_link_accumulator_top.sv
// Top level of the read pair link accumulator.
// The block takes beats on i_in (valid/ready) and returns one result beat per
// item on o_out. A beat of kind 1 writes a contig length into the length memory
// when its index is in range and answers status 0; a rejected pair answers as fast.
// A beat of kind 0 is a mate pair: both mates are checked for usability,
// their contig lengths are read from the length memory one after the other,
// and two links are built, the forward one and the mirrored one.
// Each link is a sequential scan of the edge table memory in insertion order:
// each stored edge is read from the memory and then compared. The scan ends in
// an update of the first matching edge or in an append, which fails when the
// table is full; these scans set how long a usable pair takes.
// One item is in flight at a time; the input is ready again in the cycle after
// the result is moved into the output register.
// The result sits in that output register until the receiver takes it, and a
// new item may be accepted and worked on while that result still waits; its
// own result then holds the core until the output register is free.
// Synchronous active low reset clears the edge count, the state machine and
// the slack register (to 200); the memories are not cleared, as the edge
// count marks which edge table entries hold data.
// match_slack is written through the APB port at address 0.
module read_pair_link_accumulator_top #(
    parameter int MAX_CONTIGS = rpla_pkg::MAX_CONTIGS,
    parameter int MAX_EDGES   = rpla_pkg::MAX_EDGES,
    parameter int COORD_BITS  = rpla_pkg::COORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpla_if.sink        i_in,
    rpla_if.source      o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rpla_pkg::*;

    localparam int KW = $clog2(MAX_CONTIGS);
    localparam int CW = COORD_BITS + 2;
    localparam logic signed [CW-1:0] LIM_HI = CW'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [CW-1:0] LIM_LO = -CW'(64'sd1 <<< (COORD_BITS - 1));

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LEN  = 7'b0000010,
        S_PREP = 7'b0000100,
        S_FWD  = 7'b0001000,
        S_MIR  = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_WAIT = 7'b1000000
    } t_state;

    // Configuration.
    logic [15:0] r_slack;
    assign pready = 1'b1;
    assign prdata = {16'd0, r_slack};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slack <= SLACK_RESET;
        end else if (psel && penable && pwrite && paddr[1:0] == {REG_MATCH_SLACK, 1'b0}) begin
            r_slack <= pwdata[15:0];
        end
    end

    t_state r_state, n_state;
    t_in    r_item;
    t_out   r_res;
    t_out   r_work;
    logic   r_res_valid;

    // Contig length memory, one port used for both mates, one after the other.
    logic [27:0] len_mem [MAX_CONTIGS];
    logic [27:0] r_len_rd;
    logic [KW-1:0] len_addr;
    logic        len_we;
    logic [27:0] r_len_a;

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            len_mem[len_addr] <= r_item.start_a;
        end
        r_len_rd <= len_mem[len_addr];
    end

    logic signed [11:0] ca, cb;
    assign ca = 12'($signed(r_item.contig_a));
    assign cb = 12'($signed(r_item.contig_b));
    logic bad_a, bad_b, load_ok;
    assign load_ok = (ca >= 0) && (ca < 12'sd2047) && (32'(ca) < MAX_CONTIGS);
    assign bad_a = !((ca >= 0) && (32'(ca) < MAX_CONTIGS)) || r_item.flags_a[1] ||
                   (r_item.hits_a > 8'd1);
    assign bad_b = !((cb >= 0) && (32'(cb) < MAX_CONTIGS)) || r_item.flags_b[1] ||
                   (r_item.hits_b > 8'd1);

    // Status of an item that ends right after the usability checks.
    logic [2:0] len_status;
    always_comb begin
        if (r_item.kind)  len_status = ST_LOADED;
        else if (bad_a)   len_status = ST_BAD_A;
        else if (bad_b)   len_status = ST_BAD_B;
        else              len_status = ST_SAME;
    end

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [CW-1:0] x);
        if (x > LIM_HI) return COORD_BITS'(LIM_HI);
        if (x < LIM_LO) return COORD_BITS'(LIM_LO);
        return COORD_BITS'(x);
    endfunction

    // Interval computation from the registered lengths.
    logic signed [CW-1:0] la, lb, sa, sb, pa, pb;
    assign la = CW'({1'b0, r_len_a});
    assign lb = CW'({1'b0, r_len_rd});
    assign sa = CW'({1'b0, r_item.start_a});
    assign sb = CW'({1'b0, r_item.start_b});
    assign pa = sa + CW'({1'b0, r_item.span_a});
    assign pb = sb + CW'({1'b0, r_item.span_b});

    logic signed [COORD_BITS-1:0] r_f1, r_g1, r_f2, r_g2, r_mf1, r_mg1, r_mf2, r_mg2;
    logic signed [COORD_BITS-1:0] c_f1, c_g1, c_f2, c_g2;
    logic [27:0] r_lb;
    always_comb begin
        c_f1 = r_item.flags_a[0] ? sat(la - pa) : sat(sa);
        c_g1 = r_item.flags_a[0] ? sat(la - sa) : sat(pa);
        c_f2 = r_item.flags_b[0] ? sat(sb) : sat(lb - pb);
        c_g2 = r_item.flags_b[0] ? sat(pb) : sat(lb - sb);
    end

    logic [10:0] va, vb;
    assign va = 11'({ca[9:0], r_item.flags_a[0]});
    assign vb = 11'({cb[9:0], ~r_item.flags_b[0]});

    // Edge engine shared by both links.
    logic eng_start;
    logic [10:0] eng_v1, eng_v2;
    logic signed [COORD_BITS-1:0] eng_f1, eng_g1, eng_f2, eng_g2;
    t_link_res eng_res;
    logic r_fwd_ok;

    rpla_edge_engine #(.MAX_EDGES(MAX_EDGES), .COORD_BITS(COORD_BITS)) u_eng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (eng_start),
        .i_v1    (eng_v1),
        .i_v2    (eng_v2),
        .i_f1    (eng_f1),
        .i_g1    (eng_g1),
        .i_f2    (eng_f2),
        .i_g2    (eng_g2),
        .i_slack (r_slack),
        .o_res   (eng_res)
    );

    logic r_started;
    always_comb begin
        eng_v1 = va; eng_v2 = vb;
        eng_f1 = r_f1; eng_g1 = r_g1; eng_f2 = r_f2; eng_g2 = r_g2;
        if (r_state == S_MIR) begin
            eng_v1 = vb ^ 11'd1; eng_v2 = va ^ 11'd1;
            eng_f1 = r_mf1; eng_g1 = r_mg1; eng_f2 = r_mf2; eng_g2 = r_mg2;
        end
    end
    assign eng_start = ((r_state == S_FWD) || (r_state == S_MIR)) && !r_started;

    // The input is open while the core is idle, even if a result is waiting.
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_res_valid;
    assign o_out.data  = r_res;

    // Mate a's length is read in S_LEN and mate b's in S_PREP.
    always_comb begin
        len_we   = 1'b0;
        len_addr = ca[KW-1:0];
        n_state  = r_state;
        unique case (r_state)
            S_IDLE: if (i_in.valid) n_state = S_LEN;
            S_LEN:  begin
                if (r_item.kind) begin
                    len_we  = load_ok;
                    n_state = S_OUT;
                end else if (bad_a || bad_b || ca == cb) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                len_addr = cb[KW-1:0];
                n_state  = S_WAIT;
            end
            S_WAIT: n_state = S_FWD;
            S_FWD:  if (eng_res.done) n_state = S_MIR;
            S_MIR:  if (eng_res.done) n_state = S_OUT;
            S_OUT:  if (!r_res_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.data;
        end
        if (r_state == S_PREP) begin
            r_len_a <= r_len_rd;
        end
        if (r_state == S_WAIT) begin
            r_f1 <= c_f1; r_g1 <= c_g1; r_f2 <= c_f2; r_g2 <= c_g2;
            r_lb <= r_len_rd;
        end
        // The mirrored intervals are only needed once the forward link is done.
        if (r_state == S_FWD) begin
            r_mf1 <= sat(CW'({1'b0, r_lb}) - CW'(r_g2));
            r_mg1 <= sat(CW'({1'b0, r_lb}) - CW'(r_f2));
            r_mf2 <= sat(la - CW'(r_g1));
            r_mg2 <= sat(la - CW'(r_f1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_started   <= 1'b0;
            r_fwd_ok    <= 1'b0;
            r_res       <= '0;
            r_work      <= '0;
        end else begin
            r_state <= n_state;
            r_started <= ((r_state == S_FWD) || (r_state == S_MIR)) && !eng_res.done;
            if (r_state == S_LEN) begin
                r_work <= t_out'{len_status, 12'd0, 1'b0, 12'd0, 1'b0};
            end
            if (r_state == S_FWD && eng_res.done) begin
                r_fwd_ok                <= eng_res.ok;
                r_work.forward_edge     <= eng_res.edge_idx;
                r_work.forward_created  <= eng_res.created;
            end
            if (r_state == S_MIR && eng_res.done) begin
                r_work.mirror_edge    <= eng_res.edge_idx;
                r_work.mirror_created <= eng_res.created;
                r_work.status <= (r_fwd_ok && eng_res.ok) ? ST_UPDATED : ST_FULL;
            end
            // The finished result moves to the output register once it is free.
            if (r_state == S_OUT && (!r_res_valid || o_out.ready)) begin
                r_res       <= r_work;
                r_res_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end
endmodule

// File: design/rpla_checker.sv
// Port-level checker for the link accumulator, bound to the top level.
`include "read_pair_link_accumulator_top_macros.svh"
module rpla_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_status,
    input logic       out_fc,
    input logic       out_mc
);
    import rpla_pkg::*;
    `RPLA_ASSERT_IMP(a_status_range, i_clk, i_rst_n, out_valid, out_status <= ST_FULL)
    `RPLA_ASSERT_IMP(a_created_upd, i_clk, i_rst_n, out_valid && (out_fc || out_mc),
        out_status == ST_UPDATED || out_status == ST_FULL)
    `RPLA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
    `RPLA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
endmodule

bind read_pair_link_accumulator_top rpla_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (i_in.valid),
    .in_ready   (i_in.ready),
    .out_valid  (o_out.valid),
    .out_ready  (o_out.ready),
    .out_status (o_out.data.status),
    .out_fc     (o_out.data.forward_created),
    .out_mc     (o_out.data.mirror_created)
);

// File: bench/read_pair_link_accumulator_top_tb.sv
// Self-checking bench for the read pair link accumulator: directed table, then random beats.
`timescale 1ns / 100ps

module read_pair_link_accumulator_top_tb;
    import rpla_pkg::*;

    // Cycles without any beat on either channel before the run is declared hung.
    // A pair scans the edge table at most twice, once per link, so a few
    // hundred stored edges plus the long receiver hold-off stay far below this.
    localparam int STALL_LIMIT = 40000;
    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_TAIL = 60;

    typedef struct {
        t_in  beat;
        bit   typed;
        t_out res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rpla_if #(.T(t_in))  in_if ();
    rpla_if #(.T(t_out)) out_if ();

    read_pair_link_accumulator_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the block's state, kept up to date at every accepted input beat.
    longint      slack_q = SLACK_RESET;
    int unsigned len_mem [MAX_CONTIGS];
    int unsigned e_src [MAX_EDGES];
    int unsigned e_dst [MAX_EDGES];
    longint      e_sb [MAX_EDGES];
    longint      e_se [MAX_EDGES];
    longint      e_db [MAX_EDGES];
    longint      e_de [MAX_EDGES];
    int unsigned e_wt [MAX_EDGES];
    int          e_cnt = 0;

    t_out pending_q[$];
    int   fail_cnt = 0;
    bit   idle_on = 1'b1;
    int   hold_len = 0;
    int   quiet_cyc = 0;

    // Contigs whose lengths get loaded up front; well-formed pairs only use these.
    int pool [5] = '{0, 1, 2, 3, 1023};

    function automatic longint sat_c(longint x);
        longint lim;
        lim = 64'sd1 <<< (COORD_BITS - 1);
        if (x >= lim) return lim - 1;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic bit in_win(longint x, longint lo, longint hi, longint s);
        return (lo - s <= x) && (x <= hi + s);
    endfunction

    // Ascending intervals match only ascending edges and descending only descending;
    // either way the test is an overlap of the two spans widened by the slack.
    function automatic bit iv_match(longint b, longint e, longint f, longint g, longint s);
        if (f < g) begin
            if (b >= e) return 1'b0;
            return in_win(f, b, e, s) || in_win(g, b, e, s) ||
                   in_win(b, f, g, s) || in_win(e, f, g, s);
        end
        if (b <= e) return 1'b0;
        return in_win(f, e, b, s) || in_win(g, e, b, s) ||
               in_win(b, g, f, s) || in_win(e, g, f, s);
    endfunction

    function automatic void widen(inout longint b, inout longint e, input longint f,
                                  input longint g);
        if (f < g) begin
            if (f < b) b = f;
            if (g > e) e = g;
        end else begin
            if (f > b) b = f;
            if (g < e) e = g;
        end
    endfunction

    // Finds the first matching edge in insertion order or appends one.
    // Returns 0 when an append was needed but the table is full.
    function automatic bit add_link(int unsigned v1, longint f1, longint g1,
                                    int unsigned v2, longint f2, longint g2,
                                    output logic [11:0] idx, output logic cr);
        idx = '0;
        cr = 1'b0;
        for (int i = 0; i < e_cnt; i++) begin
            if (e_src[i] == v1 && e_dst[i] == v2 &&
                iv_match(e_sb[i], e_se[i], f1, g1, slack_q) &&
                iv_match(e_db[i], e_de[i], f2, g2, slack_q)) begin
                widen(e_sb[i], e_se[i], f1, g1);
                widen(e_db[i], e_de[i], f2, g2);
                if (e_wt[i] != 32'hFFFF_FFFF) e_wt[i]++;
                idx = 12'(i);
                return 1'b1;
            end
        end
        if (e_cnt >= MAX_EDGES) return 1'b0;
        e_src[e_cnt] = v1 & 11'h7FF;
        e_dst[e_cnt] = v2 & 11'h7FF;
        e_sb[e_cnt] = f1;
        e_se[e_cnt] = g1;
        e_db[e_cnt] = f2;
        e_de[e_cnt] = g2;
        e_wt[e_cnt] = 1;
        idx = 12'(e_cnt);
        cr = 1'b1;
        e_cnt++;
        return 1'b1;
    endfunction

    function automatic t_out predict_link_result(t_in b);
        t_out   r;
        int     ca, cb;
        longint lena, lenb, sa, la, sb, lb, f1, g1, f2, g2;
        int unsigned va, vb;
        bit     ok1, ok2;
        r = '0;
        ca = $signed(b.contig_a);
        cb = $signed(b.contig_b);
        if (b.kind) begin
            if (ca >= 0 && ca < MAX_CONTIGS) len_mem[ca] = b.start_a;
            r.status = ST_LOADED;
            return r;
        end
        if (ca < 0 || ca >= MAX_CONTIGS || b.flags_a[1] || b.hits_a > 1) begin
            r.status = ST_BAD_A;
            return r;
        end
        if (cb < 0 || cb >= MAX_CONTIGS || b.flags_b[1] || b.hits_b > 1) begin
            r.status = ST_BAD_B;
            return r;
        end
        if (ca == cb) begin
            r.status = ST_SAME;
            return r;
        end
        lena = len_mem[ca];
        lenb = len_mem[cb];
        sa = b.start_a;
        la = b.span_a;
        sb = b.start_b;
        lb = b.span_b;
        // Mate a keeps its strand; mate b takes the opposite strand vertex.
        va = 2 * ca + b.flags_a[0];
        vb = 2 * cb + (b.flags_b[0] ^ 1'b1);
        if (b.flags_a[0]) begin
            f1 = sat_c(lena - (sa + la));
            g1 = sat_c(lena - sa);
        end else begin
            f1 = sat_c(sa);
            g1 = sat_c(sa + la);
        end
        if (!b.flags_b[0]) begin
            f2 = sat_c(lenb - (sb + lb));
            g2 = sat_c(lenb - sb);
        end else begin
            f2 = sat_c(sb);
            g2 = sat_c(sb + lb);
        end
        ok1 = add_link(va, f1, g1, vb, f2, g2, r.forward_edge, r.forward_created);
        ok2 = add_link(vb ^ 1, sat_c(lenb - g2), sat_c(lenb - f2),
                       va ^ 1, sat_c(lena - g1), sat_c(lena - f1),
                       r.mirror_edge, r.mirror_created);
        r.status = (ok1 && ok2) ? ST_UPDATED : ST_FULL;
        return r;
    endfunction

    function automatic t_in mk(logic kind, int ca, int fa, int ha, int sa, int la,
                               int cb, int fb, int hb, int sb, int lb);
        t_in b;
        b.kind = kind;
        b.contig_a = 11'(ca);
        b.flags_a = 2'(fa);
        b.hits_a = 8'(ha);
        b.start_a = 28'(sa);
        b.span_a = 16'(la);
        b.contig_b = 11'(cb);
        b.flags_b = 2'(fb);
        b.hits_b = 8'(hb);
        b.start_b = 28'(sb);
        b.span_b = 16'(lb);
        return b;
    endfunction

    function automatic t_out st(logic [2:0] s);
        t_out r;
        r = '0;
        r.status = s;
        return r;
    endfunction

    // Offers one beat, optionally after an idle burst, and records its expectation
    // at the edge where it is taken. valid is only lowered inside a burst.
    task automatic send_beat(t_in b, bit typed, t_out tres);
        t_out p;
        if (idle_on && $urandom_range(0, 2) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        p = predict_link_result(b);
        pending_q.push_back(typed ? tres : p);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Writes match_slack through the register port, then reads it back.
    task automatic set_slack(logic [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'(4 * REG_MATCH_SLACK);
        pwdata <= {16'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        slack_q = val;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[15:0] !== val) begin
            $error("match_slack readback exp %0d got %0d", val, prdata[15:0]);
            fail_cnt++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random beat: mostly well-formed pairs over the loaded contigs, clustered
    // around two anchors per contig so that links keep hitting existing edges.
    function automatic t_in rand_beat();
        t_in b;
        int  r, ia, ib;
        r = $urandom_range(0, 99);
        b.kind = 1'b0;
        b.contig_a = 11'($urandom_range(0, 1024) - 1);
        b.flags_a = 2'($urandom);
        b.hits_a = 8'($urandom);
        b.start_a = 28'($urandom);
        b.span_a = 16'($urandom);
        b.contig_b = 11'($urandom_range(0, 1024) - 1);
        b.flags_b = 2'($urandom);
        b.hits_b = 8'($urandom);
        b.start_b = 28'($urandom);
        b.span_b = 16'($urandom);
        if (r < 8) begin
            // Length load: either a pool contig with a modest length or anywhere else.
            b.kind = 1'b1;
            if ($urandom_range(0, 1)) begin
                b.contig_a = 11'(pool[$urandom_range(0, 4)]);
                b.start_a = 28'($urandom_range(20000, 200000));
            end else if ($signed(b.contig_a) >= 0 && $signed(b.contig_a) < 1023 &&
                         $signed(b.contig_a) > 3) begin
                b.contig_a = b.contig_a;
            end else begin
                b.contig_a = 11'h7FF;
            end
        end else if (r < 16) begin
            // Mate a unusable.
            b.hits_a = 8'($urandom_range(2, 255));
        end else if (r < 24) begin
            // Mate a good unless its contig is the unmapped index, mate b unusable.
            b.flags_a[1] = 1'b0;
            b.hits_a = 8'($urandom_range(0, 1));
            if ($urandom_range(0, 1)) b.contig_b = 11'h7FF;
            else b.flags_b[1] = 1'b1;
        end else begin
            ia = $urandom_range(0, 4);
            ib = (ia + $urandom_range(1, 4)) % 5;
            if ($urandom_range(0, 19) == 0) ib = ia;
            b.contig_a = 11'(pool[ia]);
            b.contig_b = 11'(pool[ib]);
            b.flags_a[1] = 1'b0;
            b.flags_b[1] = 1'b0;
            b.hits_a = 8'($urandom_range(0, 1));
            b.hits_b = 8'($urandom_range(0, 1));
            if ($urandom_range(0, 29) != 0) begin
                b.start_a = 28'($urandom_range(0, 1) * 20000 + $urandom_range(0, 400));
                b.span_a = 16'($urandom_range(0, 150));
                b.start_b = 28'($urandom_range(0, 1) * 20000 + $urandom_range(0, 400));
                b.span_b = 16'($urandom_range(0, 150));
            end
        end
        return b;
    endfunction

    // Receiver: random stall bursts, plus one long hold-off requested by the main flow.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_len > 0) begin
            out_if.ready <= 1'b0;
            hold_len--;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            out_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 10);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, int e, int a);
        if (e != a) begin
            $error("%s exp %0d got %0d", name, e, a);
            fail_cnt++;
        end
    endfunction

    // Result checker: each result beat is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_q.size() == 0) begin
                $error("result beat with no expectation waiting");
                fail_cnt++;
            end else begin
                check_field("status", pending_q[0].status, out_if.data.status);
                check_field("forward_edge", pending_q[0].forward_edge,
                            out_if.data.forward_edge);
                check_field("forward_created", pending_q[0].forward_created,
                            out_if.data.forward_created);
                check_field("mirror_edge", pending_q[0].mirror_edge,
                            out_if.data.mirror_edge);
                check_field("mirror_created", pending_q[0].mirror_created,
                            out_if.data.mirror_created);
                void'(pending_q.pop_front());
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !i_rst_n)
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    t_row rows[$];

    initial begin
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Loads and rejections have obvious results; pairs go to the predictor.
        rows.push_back('{mk(1, 0, 0, 0, 100000, 0, 0, 0, 0, 0, 0), 1, st(ST_LOADED)});
        rows.push_back('{mk(1, 1, 0, 0, 50000, 0, 0, 0, 0, 0, 0), 1, st(ST_LOADED)});
        rows.push_back('{mk(1, 2, 3, 255, 28'hFFFFFFF, 16'hFFFF, 1023, 3, 255,
                            28'hFFFFFFF, 16'hFFFF), 1, st(ST_LOADED)});
        rows.push_back('{mk(1, 1023, 0, 0, 70000, 0, 0, 0, 0, 0, 0), 1, st(ST_LOADED)});
        // A load to the unmapped index is dropped but still answered.
        rows.push_back('{mk(1, -1, 0, 0, 12345, 0, 0, 0, 0, 0, 0), 1, st(ST_LOADED)});
        rows.push_back('{mk(1, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, st(ST_LOADED)});
        rows.push_back('{mk(0, -1, 0, 0, 10, 10, 1, 0, 0, 10, 10), 1, st(ST_BAD_A)});
        rows.push_back('{mk(0, 0, 2, 1, 10, 10, 1, 0, 0, 10, 10), 1, st(ST_BAD_A)});
        rows.push_back('{mk(0, 0, 0, 2, 10, 10, 1, 0, 0, 10, 10), 1, st(ST_BAD_A)});
        // Mate a is checked before mate b even when both are broken.
        rows.push_back('{mk(0, 0, 3, 255, 10, 10, -1, 2, 9, 10, 10), 1, st(ST_BAD_A)});
        rows.push_back('{mk(0, 0, 0, 1, 10, 10, -1, 0, 0, 10, 10), 1, st(ST_BAD_B)});
        rows.push_back('{mk(0, 0, 1, 0, 10, 10, 1, 2, 1, 10, 10), 1, st(ST_BAD_B)});
        rows.push_back('{mk(0, 1023, 0, 1, 10, 10, 1, 1, 200, 10, 10), 1, st(ST_BAD_B)});
        rows.push_back('{mk(0, 1023, 0, 1, 10, 10, 1023, 1, 1, 10, 10), 1, st(ST_SAME)});
        rows.push_back('{mk(0, 0, 0, 1, 1000, 100, 1, 0, 1, 2000, 100), 0, '0});
        rows.push_back('{mk(0, 0, 0, 0, 1150, 80, 1, 0, 0, 2100, 50), 0, '0});
        rows.push_back('{mk(0, 0, 0, 0, 9000, 80, 1, 0, 0, 2100, 50), 0, '0});
        rows.push_back('{mk(0, 1, 1, 1, 500, 60, 1023, 1, 1, 600, 70), 0, '0});
        // Zero spans give degenerate intervals, which count as descending.
        rows.push_back('{mk(0, 1, 1, 1, 500, 0, 1023, 0, 0, 600, 0), 0, '0});
        rows.push_back('{mk(0, 1, 1, 1, 510, 0, 1023, 0, 0, 590, 0), 0, '0});
        rows.push_back('{mk(0, 2, 1, 0, 28'hFFFFFFF, 16'hFFFF, 3, 0, 1, 28'hFFFFFFF,
                            16'hFFFF), 0, '0});
        rows.push_back('{mk(0, 3, 0, 0, 0, 0, 2, 1, 0, 0, 16'hFFFF), 0, '0});
        rows.push_back('{mk(0, 1023, 1, 1, 69000, 900, 0, 1, 1, 99000, 900), 0, '0});
        foreach (rows[i]) send_beat(rows[i].beat, rows[i].typed, rows[i].res);
        drain_results();

        // Random phases at the slack extremes and one value in between.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: set_slack(16'd0);
                1: set_slack(16'hFFFF);
                default: set_slack(16'($urandom_range(100, 400)));
            endcase
            for (int n = 0; n < (ph == 2 ? RANDOM_ITEMS / 2 : RANDOM_ITEMS / 4); n++) begin
                // Long receiver hold-off while the sender keeps offering beats.
                if (ph == 1 && n == 10) hold_len = 300;
                // Sender waits for every outstanding result before carrying on.
                if (ph == 1 && n == 60) begin
                    in_if.valid <= 1'b0;
                    while (pending_q.size() != 0) @(posedge i_clk);
                end
                if (ph == 2 && n == RANDOM_ITEMS / 2 - QUIET_TAIL) idle_on = 1'b0;
                send_beat(rand_beat(), 1'b0, '0);
            end
            drain_results();
        end
        set_slack(SLACK_RESET);

        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
